// ===== hdl/sva_pkg.sv =====
// constants, codes and helpers for the synth voice allocator
// no dependencies; imported by synth_voice_allocator and its testbench
package sva_pkg;

  // number of voices and notes
  localparam int unsigned VOICES = 16;
  localparam int unsigned NOTES  = 128;

  // voice index width and free count width
  localparam int unsigned VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned CW = $clog2(VOICES + 1);
  localparam int unsigned NW = 7;

  // event kinds on the input tuser
  localparam logic REQ_ON  = 1'b0;
  localparam logic REQ_OFF = 1'b1;

  // result status codes
  typedef enum logic [2:0] {
    ST_STARTED  = 3'd0,
    ST_RELEASED = 3'd1,
    ST_NO_FREE  = 3'd2,
    ST_PLAYING  = 3'd3,
    ST_SILENT   = 3'd4
  } status_e;

  // one result beat
  typedef struct packed {
    logic [3:0] voice;
    status_e    status;
  } result_t;

  // low four bits of an internal voice number
  function automatic logic [3:0] voice_out(input logic [VW-1:0] v);
    logic [VW+3:0] tmp;
    tmp = {4'b0000, v};
    return tmp[3:0];
  endfunction

endpackage

// ===== hdl/synth_voice_allocator.sv =====
// synth voice allocator: free voice stack and note map held in memories
// depends on sva_pkg
//
// Each note event is handled in two steps: the accept cycle reads the top of the free
// stack and the note's voice from their synchronous memories, and the next
// cycle decides, writes back and loads the result register. No new beat is
// taken while the block decides, nor while a result waits; a waiting result
// holds the input only until it is taken. There is no clearing pass after
// reset: the free stack reads its reset contents through per-entry valid bits
// and the playing flags are flip-flops cleared by reset.
module synth_voice_allocator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [6:0] note, [7] zero
  input  logic [0:0] s_axis_tuser_i,   // [0] req_type
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [3:0] voice, [7:4] zero
  output logic [2:0] m_axis_tuser_o    // [2:0] status
);
  import sva_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic           state_q, state_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [NOTES-1:0]  play_q, play_d;
  logic [VOICES-1:0] stk_vld_q, stk_vld_d;
  logic [NW-1:0]  note_q;
  logic           off_q;
  logic           out_vld_q, out_vld_d;
  result_t        res_q, res_d;

  logic [VW-1:0]  stk_mem [VOICES];
  logic [VW-1:0]  nv_mem  [NOTES];
  logic [VW-1:0]  stk_rd_q, stk_rda_q, nv_rd_q;
  logic           stk_rdv_q;

  logic           in_acc;
  logic [CW-1:0]  top_c;
  logic [VW-1:0]  top_idx, push_idx, top_voice;
  logic           stk_we, nv_we;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign top_c   = cnt_q - CW'(1);
  assign top_idx = top_c[VW-1:0];
  assign push_idx = cnt_q[VW-1:0];
  // unwritten stack entries read as their reset contents, entry i holds voice i
  assign top_voice = stk_rdv_q ? stk_rd_q : stk_rda_q;

  // input ready while idle and the result slot is free or draining
  assign s_axis_tready_o = (state_q == S_IDLE) && (!out_vld_q || m_axis_tready_i);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'b0000, res_q.voice};
  assign m_axis_tuser_o  = res_q.status;

  // decide and write back
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    play_d    = play_q;
    stk_vld_d = stk_vld_q;
    out_vld_d = out_vld_q && !m_axis_tready_i;
    res_d     = res_q;
    stk_we    = 1'b0;
    nv_we     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d   = S_IDLE;
        out_vld_d = 1'b1;
        if (off_q == REQ_ON) begin
          if (cnt_q == '0) begin
            res_d = '{voice: 4'd0, status: ST_NO_FREE};
          end else if (play_q[note_q]) begin
            res_d = '{voice: 4'd0, status: ST_PLAYING};
          end else begin
            cnt_d          = top_c;
            play_d[note_q] = 1'b1;
            nv_we          = 1'b1;
            res_d = '{voice: voice_out(top_voice), status: ST_STARTED};
          end
        end else begin
          if (!play_q[note_q]) begin
            res_d = '{voice: 4'd0, status: ST_SILENT};
          end else begin
            // push is skipped on a full stack, binding still cleared
            if (cnt_q < CW'(VOICES)) begin
              stk_we              = 1'b1;
              stk_vld_d[push_idx] = 1'b1;
              cnt_d               = cnt_q + CW'(1);
            end
            play_d[note_q] = 1'b0;
            res_d = '{voice: voice_out(nv_rd_q), status: ST_RELEASED};
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= CW'(VOICES);
      play_q    <= '0;
      stk_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      play_q    <= play_d;
      stk_vld_q <= stk_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_acc) begin
      note_q <= s_axis_tdata_i[NW-1:0];
      off_q  <= s_axis_tuser_i[0];
    end
  end

  // free stack memory, registered read of the top entry every cycle
  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[push_idx] <= nv_rd_q;
    stk_rd_q  <= stk_mem[top_idx];
    stk_rda_q <= top_idx;
    stk_rdv_q <= stk_vld_q[top_idx];
  end

  // note to voice memory, read of the event's note on accept
  always_ff @(posedge clk_i) begin
    if (nv_we) nv_mem[note_q] <= top_voice;
    if (in_acc) nv_rd_q <= nv_mem[s_axis_tdata_i[NW-1:0]];
  end

  // checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(VOICES))
    else $error("free count above voice count");

  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> !out_vld_q)
    else $error("result slot busy while deciding");

  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |=> (out_vld_q && state_q == S_IDLE))
    else $error("decision did not load a result");

  a_acc_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_EXEC))
    else $error("accepted beat not processed");

endmodule

// ===== sim/tb_synth_voice_allocator.sv =====
// self-checking testbench for synth_voice_allocator: note event beats in, voice results out
// depends on sva_pkg and synth_voice_allocator; predicts each result with its own model
`timescale 1ns / 100ps

module tb_synth_voice_allocator;
  import sva_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned POOL_SIZE      = 24;
  localparam int unsigned TAIL_CYCLES    = 10;

  // predicted allocator state and queue of expected result beats
  class voice_predictor;
    logic [VW-1:0] free_voices [VOICES];
    int unsigned   free_count;
    bit            playing [NOTES];
    logic [VW-1:0] bound_voice [NOTES];
    result_t       expected_results [$];
    int unsigned   error_cnt;

    function new();
      for (int unsigned i = 0; i < VOICES; i++) free_voices[i] = VW'(i);
      for (int unsigned n = 0; n < NOTES; n++) begin
        playing[n]     = 1'b0;
        bound_voice[n] = '0;
      end
      free_count = VOICES;
      error_cnt  = 0;
    endfunction

    // count a failure, report only the first few
    function void log_failure(string what);
      if (error_cnt < MAX_REPORTS) $display("[%0t] MISMATCH: %s", $time, what);
      error_cnt++;
    endfunction

    // accepted input beat: update the model and queue the result it causes
    function void note_event(logic req, logic [NW-1:0] note);
      result_t       r;
      logic [VW-1:0] v;
      logic [VW+3:0] wide;
      r.voice = '0;
      if (req == REQ_ON) begin
        // no free voice is tested before the already-playing case
        if (free_count == 0) begin
          r.status = ST_NO_FREE;
        end else if (playing[note]) begin
          r.status = ST_PLAYING;
        end else begin
          free_count--;
          v                 = free_voices[free_count];
          bound_voice[note] = v;
          playing[note]     = 1'b1;
          wide              = {4'b0000, v};
          r.voice           = wide[3:0];
          r.status          = ST_STARTED;
        end
      end else begin
        if (!playing[note]) begin
          r.status = ST_SILENT;
        end else begin
          v = bound_voice[note];
          // guard against a full stack: binding still cleared
          if (free_count < VOICES) begin
            free_voices[free_count] = v;
            free_count++;
          end
          playing[note] = 1'b0;
          wide          = {4'b0000, v};
          r.voice       = wide[3:0];
          r.status      = ST_RELEASED;
        end
      end
      expected_results.push_back(r);
    endfunction

    // accepted result beat: compare with the oldest expectation
    function void check_result(logic [3:0] voice, logic [2:0] status);
      result_t exp_r;
      if (expected_results.size() == 0) begin
        log_failure($sformatf("result beat voice=%0d status=%0d with nothing expected",
                              voice, status));
        return;
      end
      exp_r = expected_results.pop_front();
      if (voice !== exp_r.voice)
        log_failure($sformatf("voice expected %0d actual %0d (status expected %0d)",
                              exp_r.voice, voice, exp_r.status));
      if (status !== exp_r.status)
        log_failure($sformatf("status expected %0d actual %0d", exp_r.status, status));
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       s_axis_tvalid_i;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i;   // [6:0] note, [7] zero
  logic [0:0] s_axis_tuser_i;   // [0] req_type
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i;
  logic [7:0] m_axis_tdata_o;   // [3:0] voice, [7:4] zero
  logic [2:0] m_axis_tuser_o;   // [2:0] status

  voice_predictor sb = new();

  bit          tx_idle_on  = 1'b1;
  bit          rx_idle_on  = 1'b1;
  bit          rx_hold_req = 1'b0;
  int unsigned quiet_cycles = 0;
  logic [NW-1:0] note_pool [POOL_SIZE];

  synth_voice_allocator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // 12 ns clock
  always #6 clk_i = ~clk_i;

  // result side: random stall bursts, plus one long hold-off on request
  initial begin : result_ready_driver
    int unsigned gap_left;
    int unsigned hold_left;
    gap_left  = 0;
    hold_left = 0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = $urandom_range(250, 350);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (!rx_idle_on) begin
        m_axis_tready_i <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        m_axis_tready_i <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 15) - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // beat monitor on both sides and watchdog on quiet cycles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        sb.note_event(s_axis_tuser_i[0], s_axis_tdata_i[NW-1:0]);
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_result(m_axis_tdata_o[3:0], m_axis_tuser_o);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no beat for %0d cycles", $time, quiet_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // offer one event beat and hold it until taken, then maybe idle
  task automatic send_event(input logic req, input logic [NW-1:0] note);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= req;
    s_axis_tdata_i  <= {1'b0, note};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // random events: mostly a small note pool so voices fill and drain,
  // the note-on share swings every few dozen beats
  task automatic play_random(input int unsigned count);
    int unsigned   on_pct;
    logic          req;
    logic [NW-1:0] note;
    on_pct = 50;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 0) on_pct = $urandom_range(0, 1) ? 75 : 30;
      req = ($urandom_range(0, 99) < on_pct) ? REQ_ON : REQ_OFF;
      if ($urandom_range(0, 9) == 0) note = NW'($urandom_range(0, NOTES - 1));
      else note = note_pool[$urandom_range(0, POOL_SIZE - 1)];
      send_event(req, note);
    end
  endtask

  // hold the input side idle until every expected result has come,
  // checked after each edge so the last accepted beat is already queued
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_results.size() != 0);
  endtask

  initial begin : stimulus
    logic [NW-1:0] fill_notes [16];
    fill_notes = '{7'd1, 7'd2, 7'd4, 7'd8, 7'd16, 7'd32, 7'd64, 7'd127,
                   7'd126, 7'd125, 7'd123, 7'd119, 7'd111, 7'd95, 7'd63, 7'd85};
    for (int unsigned k = 0; k < POOL_SIZE; k++) note_pool[k] = NW'($urandom_range(0, NOTES - 1));

    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tuser_i  <= REQ_ON;
    s_axis_tdata_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: silent note-off, start, already playing, lowest and highest notes
    send_event(REQ_OFF, 7'd0);
    send_event(REQ_ON,  7'd0);
    send_event(REQ_ON,  7'd0);
    send_event(REQ_ON,  7'd127);
    send_event(REQ_OFF, 7'd127);
    send_event(REQ_OFF, 7'd127);
    send_event(REQ_OFF, 7'd0);
    // take every voice, then note-on with none free, playing note and new note
    for (int unsigned k = 0; k < 16; k++) send_event(REQ_ON, fill_notes[k]);
    send_event(REQ_ON, 7'd85);
    send_event(REQ_ON, 7'd100);

    // random with idling on both sides
    play_random(450);

    // long result hold-off while the input keeps offering beats
    tx_idle_on  = 1'b0;
    rx_hold_req = 1'b1;
    play_random(60);
    tx_idle_on  = 1'b1;

    // input pause until everything has drained
    wait_drained();
    @(posedge clk_i);

    play_random(390);

    // closing stretch without idling
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    play_random(150);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.expected_results.size() != 0) begin
      $display("[%0t] %0d expected results never arrived", $time, sb.expected_results.size());
      sb.error_cnt++;
    end

    if (sb.error_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
